@@ rtl/dppb_pkg.sv @@
// Shared types, codes and helpers of the dual ping-pong buffer controller.
package dppb_pkg;

	localparam int MaxCmds = 12;
	localparam int CntW = $clog2(MaxCmds + 1);
	localparam int DefBufferLines = 512;

	localparam logic [1:0] PH_EMPTY    = 2'd0;
	localparam logic [1:0] PH_FILLING  = 2'd1;
	localparam logic [1:0] PH_FULL     = 2'd2;
	localparam logic [1:0] PH_EMPTYING = 2'd3;

	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_RECEIVE = 2'd1;
	localparam logic [1:0] CMD_SEND    = 2'd2;

	localparam logic REG_SERDES_PORT = 1'b0;
	localparam logic REG_DSP_PORT    = 1'b1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] idx;
		logic [2:0] port;
		logic       pair_b;
		logic       last;
	} cmd_entry_t;

	typedef struct packed {
		logic                     vld;
		logic [CntW-1:0]          count;
		cmd_entry_t [MaxCmds-1:0] entries;
	} cmd_load_t;

	function automatic cmd_entry_t make_entry(logic [1:0] cmd, logic [1:0] idx,
			logic [2:0] port);
		cmd_entry_t e;
		e.cmd    = cmd;
		e.idx    = idx;
		e.port   = (cmd == CMD_CLEAR) ? 3'd0 : port;
		e.pair_b = idx[1];
		e.last   = 1'b0;
		return e;
	endfunction

endpackage

@@ rtl/dual_ping_pong_buffer_controller.sv @@
// Top level of the dual ping-pong buffer controller: ports, input stage, registers, checks.

// Two ping-pong pairs share this controller: pair A (buffers 0 and 1) moves DSP
// receive data to the serdes transmitter, and pair B (buffers 2 and 3) moves serdes
// receive data to the DSP transmitter. Each input transaction carries a status word
// of four done bits, handled from bit 0 to bit 3; every set bit yields a clear
// command for that buffer followed by the receive and send commands that keep the
// pair streaming, so one status word produces between one and three commands per
// set bit, at most twelve, and an all-zero word produces none. The status word is
// registered in the input stage; once the command list is free, all commands for
// it are worked out in one combinational pass and loaded into the list register,
// and the list is then handed out one command per output transaction. A word that
// yields k commands occupies the output for k output transactions. A new status
// word is taken while the previous list is still being drained, and its commands
// follow the last one of the previous list with no gap. The final command of each
// word has last_of_run set. Port numbers are configured through the write channel
// (index 0 serdes port, index 1 DSP port) and are sampled when a word is processed,
// so they should only change while the block is idle. Buffer line ranges follow
// from the BUFFER_LINES parameter and are zero on clear commands.
module dual_ping_pong_buffer_controller import dppb_pkg::*; #(
	parameter int BUFFER_LINES = DefBufferLines
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] done_bits,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] command,
	output logic [1:0] buffer_index,
	output logic [2:0] target_port,
	output logic [8:0] first_line,
	output logic [8:0] last_line,
	output logic       last_of_run,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [2:0] cfg_data
);

	// Configuration registers; writes are always taken.
	logic [2:0] serdes_port_q;
	logic [2:0] dsp_port_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serdes_port_q <= 3'd0;
			dsp_port_q    <= 3'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SERDES_PORT: serdes_port_q <= cfg_data;
				REG_DSP_PORT:    dsp_port_q    <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Input stage: holds one status word until the command list can take its
	// commands. The list is free when empty or when its last command leaves now.
	logic       valid_s1;
	logic [3:0] done_s1;
	logic       free;
	logic       fire;
	cmd_load_t  load;

	assign fire     = valid_s1 && free;
	assign in_ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			done_s1 <= done_bits;
		end
	end

	// Buffer state and command generation for the registered word.
	dppb_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.done_bits   (done_s1),
		.serdes_port (serdes_port_q),
		.dsp_port    (dsp_port_q),
		.load        (load)
	);

	// Command list drained one transaction at a time.
	dppb_queue #(
		.BUFFER_LINES (BUFFER_LINES)
	) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.free         (free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.command      (command),
		.buffer_index (buffer_index),
		.target_port  (target_port),
		.first_line   (first_line),
		.last_line    (last_line),
		.last_of_run  (last_of_run)
	);

	// A status word with no done bit set must not load any command.
	a_empty_word_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (done_s1 == 4'd0)) |-> !load.vld)
		else $error("empty status word loaded commands");

	// Every freshly loaded list starts with a clear command.
	a_list_starts_clear: assert property (@(posedge clk) disable iff (!arst_n)
		load.vld |=> (out_valid && (command == CMD_CLEAR)))
		else $error("command list does not start with a clear");

	// A loaded list never holds more commands than one word can produce.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load.vld |-> (load.count <= CntW'(MaxCmds)))
		else $error("command count out of range");

endmodule

@@ rtl/dppb_engine.sv @@
// Buffer phase and idle flag state with the single-pass command generator.
module dppb_engine import dppb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [3:0] done_bits,
	input  logic [2:0] serdes_port,
	input  logic [2:0] dsp_port,
	output cmd_load_t  load
);

	logic [3:0][1:0] phase_q;
	logic [1:0]      rx_idle_q;
	logic [1:0]      tx_idle_q;

	logic [3:0][1:0]          ph;
	logic [1:0]               rx;
	logic [1:0]               tx;
	logic [CntW-1:0]          n;
	cmd_entry_t [MaxCmds-1:0] ents;

	always_comb begin
		logic [1:0] bi;
		logic [1:0] pt;
		logic       pb;
		logic [2:0] rxp;
		logic [2:0] txp;
		ph   = phase_q;
		rx   = rx_idle_q;
		tx   = tx_idle_q;
		n    = '0;
		ents = '0;
		for (int b = 0; b < 4; b++) begin
			bi  = 2'(b);
			pb  = bi[1];
			pt  = {bi[1], ~bi[0]};
			rxp = pb ? serdes_port : dsp_port;
			txp = pb ? dsp_port : serdes_port;
			if (done_bits[b]) begin
				ents[n] = make_entry(CMD_CLEAR, bi, 3'd0);
				n = n + 1'b1;
				if (ph[b] == PH_FILLING) begin
					ph[b] = PH_FULL;
					if (ph[pt] == PH_EMPTY) begin
						ents[n] = make_entry(CMD_RECEIVE, pt, rxp);
						n = n + 1'b1;
						ph[pt] = PH_FILLING;
					end else begin
						rx[pb] = 1'b1;
					end
					if (tx[pb]) begin
						tx[pb] = 1'b0;
						ents[n] = make_entry(CMD_SEND, bi, txp);
						n = n + 1'b1;
						ph[b] = PH_EMPTYING;
					end
				end else begin
					ph[b] = PH_EMPTY;
					if (rx[pb]) begin
						rx[pb] = 1'b0;
						ents[n] = make_entry(CMD_RECEIVE, bi, rxp);
						n = n + 1'b1;
						ph[b] = PH_FILLING;
					end
					if (ph[pt] == PH_FULL) begin
						ents[n] = make_entry(CMD_SEND, pt, txp);
						n = n + 1'b1;
						ph[pt] = PH_EMPTYING;
					end else begin
						tx[pb] = 1'b1;
					end
				end
			end
		end
		if (n != '0) begin
			ents[n - 1'b1].last = 1'b1;
		end
	end

	assign load.vld     = fire && (n != '0);
	assign load.count   = n;
	assign load.entries = ents;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= {PH_EMPTY, PH_FILLING, PH_EMPTY, PH_FILLING};
			rx_idle_q <= 2'b00;
			tx_idle_q <= 2'b11;
		end else if (fire) begin
			phase_q   <= ph;
			rx_idle_q <= rx;
			tx_idle_q <= tx;
		end
	end

endmodule

@@ rtl/dppb_queue.sv @@
// Command list register that hands out one command per output transaction.
module dppb_queue import dppb_pkg::*; #(
	parameter int BUFFER_LINES = DefBufferLines
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_load_t  load,
	output logic       free,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] command,
	output logic [1:0] buffer_index,
	output logic [2:0] target_port,
	output logic [8:0] first_line,
	output logic [8:0] last_line,
	output logic       last_of_run
);

	localparam int TopLine = BUFFER_LINES - 1;
	localparam int LastA   = (509 > TopLine) ? TopLine : 509;
	localparam int FirstA  = (10 > LastA) ? LastA : 10;
	localparam int LastB   = (504 > TopLine) ? TopLine : 504;
	localparam int FirstB  = (5 > LastB) ? LastB : 5;

	cmd_entry_t [MaxCmds-1:0] ents_q;
	logic [CntW-1:0]          cnt_q;
	logic                     take;

	assign out_valid = (cnt_q != '0);
	assign take      = out_valid && out_ready;
	assign free      = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load.vld) begin
			cnt_q <= load.count;
		end else if (take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load.vld) begin
			ents_q <= load.entries;
		end else if (take) begin
			for (int i = 0; i < MaxCmds - 1; i++) begin
				ents_q[i] <= ents_q[i + 1];
			end
		end
	end

	assign command      = ents_q[0].cmd;
	assign buffer_index = ents_q[0].idx;
	assign target_port  = ents_q[0].port;
	assign last_of_run  = ents_q[0].last;

	always_comb begin
		if (ents_q[0].cmd == CMD_CLEAR) begin
			first_line = '0;
			last_line  = '0;
		end else if (ents_q[0].pair_b) begin
			first_line = 9'(FirstB);
			last_line  = 9'(LastB);
		end else begin
			first_line = 9'(FirstA);
			last_line  = 9'(LastA);
		end
	end

endmodule
